/* design/rwmc_pkg.sv */
// ----------------------------------------------------------------------------
// rwmc_pkg
// Shared constants, codes and types of the random-walk maze carver.
// ----------------------------------------------------------------------------
package rwmc_pkg;

   // Default maze size limits
   localparam int MAX_COLS_DEF = 32;
   localparam int MAX_ROWS_DEF = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0]  CSR_COLS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_ROWS  = 1'b1;
   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 6'd14;

   // Width of clamped dimension arithmetic (holds up to 64)
   localparam int DIM_CALC_W = 7;

   // Field widths of a transaction
   localparam int DIR_W  = 2;
   localparam int WALL_W = 7;
   localparam int CELL_W = 5;

   // Move directions
   localparam logic [DIR_W-1:0] DIR_WEST  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_NORTH = 2'd1;
   localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd3;

   // Status of the visited-store clearing pass
   typedef struct packed {
      logic busy;
      logic wr_bit;
   } clr_status_type;

   // Index width for a store or count of the given depth
   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Clamp a configured dimension into 1..maxv
   function automatic logic [DIM_CALC_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                                       input int maxv);
      logic [DIM_CALC_W-1:0] ext;
      logic [DIM_CALC_W-1:0] lim;
      ext = DIM_CALC_W'(v);
      lim = DIM_CALC_W'(maxv);
      if (ext == '0) begin
         return DIM_CALC_W'(1);
      end else if (ext > lim) begin
         return lim;
      end
      return ext;
   endfunction

endpackage

/* design/random_walk_maze_carver_core.sv */
// ----------------------------------------------------------------------------
// random_walk_maze_carver_core
// Transactions pass the move stage and the result register. Throughput: one
// move a cycle while the result register is not stalled and no sweep runs, set
// by the single visited-store read per move. A restart holds off requests while
// the visited store is swept. Reset: walk finished, walker at cell 0, sizes 14.
// ----------------------------------------------------------------------------
module random_walk_maze_carver_core #(
   parameter int MAX_COLS = rwmc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = rwmc_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [rwmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rwmc_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   // move requests
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   input  logic [rwmc_pkg::DIR_W-1:0]        req_direction,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_carved,
   output logic [rwmc_pkg::WALL_W-1:0]       rsp_wall_col,
   output logic [rwmc_pkg::WALL_W-1:0]       rsp_wall_row,
   output logic [rwmc_pkg::CELL_W-1:0]       rsp_cell_col,
   output logic [rwmc_pkg::CELL_W-1:0]       rsp_cell_row,
   output logic                              rsp_done_res
);
   import rwmc_pkg::*;

   localparam int COL_W  = idx_width(MAX_COLS);
   localparam int ROW_W  = idx_width(MAX_ROWS);
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = idx_width(DEPTH);
   localparam int SUM_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

   // Map a cell to its visited-store entry
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
      return ADDR_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

   // Configuration registers
   logic [CSR_DATA_W-1:0] cols_ff, rows_ff;
   logic [DIM_CALC_W-1:0] eff_cols, eff_rows;

   // Handshake control
   logic accept, out_en;

   // Move stage (between input and result register)
   logic              b_valid_ff;
   logic              b_restart_ff, b_move_ff, b_fwd_ff;
   logic [COL_W-1:0]  b_old_col_ff, b_new_col_ff;
   logic [ROW_W-1:0]  b_old_row_ff, b_new_row_ff;
   logic [ADDR_W-1:0] b_addr_ff, b_count_ff;

   // Walk progress
   logic [ADDR_W-1:0] cells_left_ff, cl_after_b, start_count;
   logic              active, visited_b, carve_b;

   // Walker
   logic [COL_W-1:0]  old_col, next_col;
   logic [ROW_W-1:0]  old_row, next_row;
   logic [ADDR_W-1:0] next_addr, walker_addr;

   // Visited store
   clr_status_type    clr;
   logic [ADDR_W-1:0] clr_addr;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [0:0]        ram_wr_data, ram_rd_data;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_carved_ff, rsp_done_ff;
   logic [WALL_W-1:0] rsp_wall_col_ff, rsp_wall_row_ff;
   logic [CELL_W-1:0] rsp_cell_col_ff, rsp_cell_row_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_RESET;
         rows_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COLS: cols_ff <= csr_wr_data;
            CSR_ROWS: rows_ff <= csr_wr_data;
            default:  cols_ff <= cols_ff;
         endcase
      end
   end

   assign eff_cols = clamp_dim(cols_ff, MAX_COLS);
   assign eff_rows = clamp_dim(rows_ff, MAX_ROWS);

   // Advance the pipeline unless the result register is blocked
   assign out_en    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !out_en || clr.busy;
   assign accept    = req_valid && !req_stall;

   // Resolve the transaction in the move stage
   assign visited_b = b_fwd_ff || ram_rd_data[0];
   assign carve_b   = b_valid_ff && b_move_ff && !visited_b;

   always_comb begin
      cl_after_b = cells_left_ff;
      if (b_valid_ff) begin
         if (b_restart_ff) begin
            cl_after_b = b_count_ff;
         end else if (carve_b) begin
            cl_after_b = cells_left_ff - 1'b1;
         end
      end
   end

   assign active      = (cl_after_b != '0);
   assign start_count = ADDR_W'(int'(eff_cols) * int'(eff_rows) - 1);

   rwmc_move #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_move (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .restart   (req_restart),
      .active    (active),
      .direction (req_direction),
      .eff_cols  (eff_cols),
      .eff_rows  (eff_rows),
      .old_col   (old_col),
      .old_row   (old_row),
      .next_col  (next_col),
      .next_row  (next_row)
   );

   assign next_addr   = cell_addr(next_col, next_row);
   assign walker_addr = cell_addr(old_col, old_row);

   // Load the move stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (out_en) begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_restart_ff <= req_restart;
         b_move_ff    <= !req_restart && active;
         // forward the bit that the leaving transaction writes this edge
         b_fwd_ff     <= b_valid_ff && b_move_ff && (b_addr_ff == next_addr);
         b_old_col_ff <= old_col;
         b_old_row_ff <= old_row;
         b_new_col_ff <= next_col;
         b_new_row_ff <= next_row;
         b_addr_ff    <= next_addr;
         b_count_ff   <= start_count;
      end
   end

   // Track cells left
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_left_ff <= '0;
      end else if (out_en && b_valid_ff) begin
         cells_left_ff <= cl_after_b;
      end
   end

   // Sweep the visited store after a restart
   rwmc_clear #(
      .DEPTH (DEPTH)
   ) u_clear (
      .clock      (clock),
      .reset      (reset),
      .start      (accept && req_restart),
      .start_addr (walker_addr),
      .status     (clr),
      .wr_addr    (clr_addr)
   );

   assign ram_wr_en      = clr.busy || (out_en && carve_b);
   assign ram_wr_addr    = clr.busy ? clr_addr : b_addr_ff;
   assign ram_wr_data[0] = clr.busy ? clr.wr_bit : 1'b1;

   rwmc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_visited (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (next_addr),
      .rd_data (ram_rd_data)
   );

   // Load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && b_valid_ff) begin
         rsp_carved_ff   <= carve_b;
         rsp_done_ff     <= (cl_after_b == '0);
         rsp_cell_col_ff <= CELL_W'(b_new_col_ff);
         rsp_cell_row_ff <= CELL_W'(b_new_row_ff);
         if (carve_b) begin
            rsp_wall_col_ff <= WALL_W'(SUM_W'(b_old_col_ff) + SUM_W'(b_new_col_ff) + 1'b1);
            rsp_wall_row_ff <= WALL_W'(SUM_W'(b_old_row_ff) + SUM_W'(b_new_row_ff) + 1'b1);
         end else begin
            rsp_wall_col_ff <= '0;
            rsp_wall_row_ff <= '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_carved   = rsp_carved_ff;
   assign rsp_wall_col = rsp_wall_col_ff;
   assign rsp_wall_row = rsp_wall_row_ff;
   assign rsp_cell_col = rsp_cell_col_ff;
   assign rsp_cell_row = rsp_cell_row_ff;
   assign rsp_done_res = rsp_done_ff;

`ifndef SYNTH
   // A broken wall lies between two cells: exactly one coordinate is even
   a_wall_between_cells: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_carved_ff) |-> (rsp_wall_col_ff[0] ^ rsp_wall_row_ff[0]))
      else $error("carved wall not between two cells");

   // No carve leaves the wall fields at zero
   a_no_carve_no_wall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_carved_ff) |-> (rsp_wall_col_ff == '0 && rsp_wall_row_ff == '0))
      else $error("wall reported without a carve");

   // A move lowers the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (out_en && b_valid_ff && !b_restart_ff) |=>
         (cells_left_ff == $past(cells_left_ff) ||
          cells_left_ff == $past(cells_left_ff) - 1'b1))
      else $error("cells left changed by more than one");

   // The sweep owns the write port: no carve may land while it runs
   a_no_carve_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr.busy |-> !(b_valid_ff && b_move_ff))
      else $error("move transaction in flight during clearing pass");
`endif

endmodule

/* design/rwmc_ram.sv */
// ----------------------------------------------------------------------------
// rwmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwmc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [rwmc_pkg::idx_width(DEPTH)-1:0]        wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [rwmc_pkg::idx_width(DEPTH)-1:0]        rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   import rwmc_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rwmc_clear.sv */
// ----------------------------------------------------------------------------
// rwmc_clear
// Sweeps the visited store after a restart, leaving only the start cell set.
// ----------------------------------------------------------------------------
module rwmc_clear #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [rwmc_pkg::idx_width(DEPTH)-1:0] start_addr,
   output rwmc_pkg::clr_status_type              status,
   output logic [rwmc_pkg::idx_width(DEPTH)-1:0] wr_addr
);
   import rwmc_pkg::*;

   localparam int ADDR_W = idx_width(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // Advance the sweep one entry a cycle, stop after the last entry
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (start) begin
         busy_in = 1'b1;
         addr_in = '0;
      end else if (busy_ff) begin
         if (addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign status.busy   = busy_ff;
   assign status.wr_bit = (addr_ff == start_addr);
   assign wr_addr       = addr_ff;

endmodule

/* design/rwmc_move.sv */
// ----------------------------------------------------------------------------
// rwmc_move
// Walker position register and the one-cell move with edge clamping.
// ----------------------------------------------------------------------------
module rwmc_move #(
   parameter int MAX_COLS = rwmc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = rwmc_pkg::MAX_ROWS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  logic                                     restart,
   input  logic                                     active,
   input  logic [rwmc_pkg::DIR_W-1:0]               direction,
   input  logic [rwmc_pkg::DIM_CALC_W-1:0]          eff_cols,
   input  logic [rwmc_pkg::DIM_CALC_W-1:0]          eff_rows,
   output logic [rwmc_pkg::idx_width(MAX_COLS)-1:0] old_col,
   output logic [rwmc_pkg::idx_width(MAX_ROWS)-1:0] old_row,
   output logic [rwmc_pkg::idx_width(MAX_COLS)-1:0] next_col,
   output logic [rwmc_pkg::idx_width(MAX_ROWS)-1:0] next_row
);
   import rwmc_pkg::*;

   localparam int COL_W = idx_width(MAX_COLS);
   localparam int ROW_W = idx_width(MAX_ROWS);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] mv_col;
   logic [ROW_W-1:0] mv_row;

   // Step one cell unless at the edge or the walk is finished
   always_comb begin
      mv_col = col_ff;
      mv_row = row_ff;
      if (active) begin
         case (direction)
            DIR_WEST: begin
               if (col_ff != '0) mv_col = col_ff - 1'b1;
            end
            DIR_NORTH: begin
               if (row_ff != '0) mv_row = row_ff - 1'b1;
            end
            DIR_EAST: begin
               if ((DIM_CALC_W'(col_ff) + 1'b1) < eff_cols) mv_col = col_ff + 1'b1;
            end
            DIR_SOUTH: begin
               if ((DIM_CALC_W'(row_ff) + 1'b1) < eff_rows) mv_row = row_ff + 1'b1;
            end
            default: begin
               mv_col = col_ff;
               mv_row = row_ff;
            end
         endcase
      end
   end

   // Restart places the walker on the last cell
   always_comb begin
      if (restart) begin
         next_col = COL_W'(eff_cols - 1'b1);
         next_row = ROW_W'(eff_rows - 1'b1);
      end else begin
         next_col = mv_col;
         next_row = mv_row;
      end
   end

   assign col_in = accept ? next_col : col_ff;
   assign row_in = accept ? next_row : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign old_col = col_ff;
   assign old_row = row_ff;

endmodule

/* bench/tb_random_walk_maze_carver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_walk_maze_carver_core
// Drives random-walk moves and restarts into the maze carver under several
// maze sizes and idling patterns. Every accepted transaction is run through
// a local model of the carver. Each result is checked field by field against
// the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_random_walk_maze_carver_core;
   import rwmc_pkg::*;

   localparam int MAX_COLS    = MAX_COLS_DEF;
   localparam int MAX_ROWS    = MAX_ROWS_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 150;
   localparam int MODE_ITEMS  = 210;

   typedef struct {
      logic             restart;
      logic [DIR_W-1:0] direction;
   } move_type;

   typedef struct {
      logic              carved;
      logic [WALL_W-1:0] wall_col;
      logic [WALL_W-1:0] wall_row;
      logic [CELL_W-1:0] cell_col;
      logic [CELL_W-1:0] cell_row;
      logic              done;
   } carve_type;

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = CSR_COLS;
   logic [CSR_DATA_W-1:0] csr_wr_data   = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic                  req_restart   = 1'b0;
   logic [DIR_W-1:0]      req_direction = DIR_WEST;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic                  rsp_carved;
   logic [WALL_W-1:0]     rsp_wall_col;
   logic [WALL_W-1:0]     rsp_wall_row;
   logic [CELL_W-1:0]     rsp_cell_col;
   logic [CELL_W-1:0]     rsp_cell_row;
   logic                  rsp_done_res;

   // Stimulus and scoreboard state
   move_type  move_backlog[$];
   carve_type carve_expected[$];
   logic   req_fire       = 1'b0;
   int     send_idle_pct  = 0;
   int     stall_pct      = 0;
   int     hold_gen       = 0;
   int     hold_seen      = 0;
   int     hold_left      = 0;
   int     mismatch_count = 0;
   int     cycle_count    = 0;

   // Local copy of the carver state
   logic [CSR_DATA_W-1:0] dim_cols = DIM_RESET;
   logic [CSR_DATA_W-1:0] dim_rows = DIM_RESET;
   bit                    cell_seen [0:MAX_COLS*MAX_ROWS-1];
   int                    walk_col;
   int                    walk_row;
   int                    cells_left;

   random_walk_maze_carver_core uut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .req_direction (req_direction),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_carved    (rsp_carved),
      .rsp_wall_col  (rsp_wall_col),
      .rsp_wall_row  (rsp_wall_row),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_done_res  (rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Effective maze size: zero counts as one, oversize counts as the maximum
   function automatic int eff_dim(input logic [CSR_DATA_W-1:0] raw, input int maxv);
      if (raw == 0) return 1;
      if (raw > maxv) return maxv;
      return raw;
   endfunction

   // Work out the result of one move and advance the walker
   function automatic void predict_carve(input move_type mv, output carve_type res);
      int ec;
      int er;
      int nc;
      int nr;
      ec = eff_dim(dim_cols, MAX_COLS);
      er = eff_dim(dim_rows, MAX_ROWS);
      res = '{default: '0};
      if (mv.restart) begin
         foreach (cell_seen[i]) cell_seen[i] = 1'b0;
         walk_col = ec - 1;
         walk_row = er - 1;
         cell_seen[walk_row*MAX_COLS + walk_col] = 1'b1;
         cells_left = ec * er - 1;
      end else if (cells_left > 0) begin
         nc = walk_col;
         nr = walk_row;
         case (mv.direction)
            DIR_WEST:  if (nc > 0) nc--;
            DIR_NORTH: if (nr > 0) nr--;
            DIR_EAST:  if (nc + 1 < ec) nc++;
            DIR_SOUTH: if (nr + 1 < er) nr++;
            default: ;
         endcase
         if (!cell_seen[nr*MAX_COLS + nc]) begin
            cell_seen[nr*MAX_COLS + nc] = 1'b1;
            cells_left--;
            res.carved   = 1'b1;
            res.wall_col = WALL_W'(walk_col + nc + 1);
            res.wall_row = WALL_W'(walk_row + nr + 1);
         end
         walk_col = nc;
         walk_row = nr;
      end
      res.cell_col = CELL_W'(walk_col);
      res.cell_row = CELL_W'(walk_row);
      res.done     = (cells_left == 0);
   endfunction

   function automatic void check_field(input string name, input logic [6:0] want,
                                       input logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Check results against the oldest prediction, then predict accepted moves
   always @(posedge clock) begin : scoreboard
      carve_type want;
      move_type  mv;
      req_fire <= !reset && req_valid && !req_stall;
      if (reset) begin
         foreach (cell_seen[i]) cell_seen[i] = 1'b0;
         walk_col   = 0;
         walk_row   = 0;
         cells_left = 0;
         carve_expected.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (carve_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual cell (%0d,%0d)",
                        $time, rsp_cell_col, rsp_cell_row);
               mismatch_count++;
            end else begin
               want = carve_expected.pop_front();
               check_field("carved", want.carved, rsp_carved);
               check_field("wall_col", want.wall_col, rsp_wall_col);
               check_field("wall_row", want.wall_row, rsp_wall_row);
               check_field("cell_col", want.cell_col, rsp_cell_col);
               check_field("cell_row", want.cell_row, rsp_cell_row);
               check_field("done_res", want.done, rsp_done_res);
            end
         end
         if (req_valid && !req_stall) begin
            mv.restart   = req_restart;
            mv.direction = req_direction;
            predict_carve(mv, want);
            carve_expected.insert(carve_expected.size(), want);
         end
      end
   end

   // Offer pending moves; hold the payload until the transaction is taken
   always @(negedge clock) begin : move_driver
      move_type mv;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (move_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            mv = move_backlog.pop_front();
            req_valid     <= 1'b1;
            req_restart   <= mv.restart;
            req_direction <= mv.direction;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall results at random, or hold off for a long stretch on request
   always @(negedge clock) begin
      if (hold_gen != hold_seen) begin
         hold_seen <= hold_gen;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, carve_expected.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic set_mode(input int idle, input int stall);
      @(posedge clock);
      send_idle_pct = idle;
      stall_pct     = stall;
   endtask

   task automatic write_dim(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      if (idx == CSR_COLS) dim_cols = value;
      else dim_rows = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_dims(input logic [CSR_DATA_W-1:0] c, input logic [CSR_DATA_W-1:0] r);
      write_dim(CSR_COLS, c);
      write_dim(CSR_ROWS, r);
   endtask

   task automatic offer(input logic restart, input logic [DIR_W-1:0] direction);
      move_type mv;
      mv.restart   = restart;
      mv.direction = direction;
      move_backlog.insert(move_backlog.size(), mv);
   endtask

   // Wait until every move is taken and answered and the store sweep is over
   task automatic wait_idle();
      do @(negedge clock);
      while (move_backlog.size() != 0 || req_valid || carve_expected.size() != 0 ||
             req_stall);
      repeat (4) @(negedge clock);
   endtask

   // Mostly small mazes so that walks finish; a few zero and oversize values
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      int p;
      p = $urandom_range(99);
      if (p < 65) return CSR_DATA_W'($urandom_range(5, 1));
      if (p < 80) return CSR_DATA_W'($urandom_range(12, 6));
      if (p < 86) return '0;
      if (p < 92) return CSR_DATA_W'($urandom_range(63, 33));
      if (p < 96) return CSR_DATA_W'(32);
      return CSR_DATA_W'($urandom_range(31, 13));
   endfunction

   initial begin : stimulus
      int mode;
      int sent;
      int n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: moves while the walk is finished after reset
      set_mode(0, 0);
      @(posedge clock);
      offer(1'b0, DIR_WEST);
      offer(1'b0, DIR_NORTH);
      offer(1'b0, DIR_EAST);
      offer(1'b0, DIR_SOUTH);
      wait_idle();

      // Restart at reset size, push against the far corner, then carve
      @(posedge clock);
      offer(1'b1, DIR_SOUTH);
      offer(1'b0, DIR_EAST);
      offer(1'b0, DIR_SOUTH);
      offer(1'b0, DIR_WEST);
      offer(1'b0, DIR_NORTH);
      wait_idle();

      // Zero sizes count as a single cell
      set_dims('0, '0);
      @(posedge clock);
      offer(1'b1, DIR_EAST);
      offer(1'b0, DIR_EAST);
      wait_idle();

      // Oversize values clamp to the full store
      set_dims('1, '1);
      @(posedge clock);
      offer(1'b1, DIR_NORTH);
      offer(1'b0, DIR_EAST);
      offer(1'b0, DIR_SOUTH);
      offer(1'b0, DIR_WEST);
      offer(1'b0, DIR_NORTH);
      offer(1'b0, DIR_WEST);
      wait_idle();

      // Shrink mid-walk: walker beyond the new edge
      set_dims(6'd2, 6'd2);
      @(posedge clock);
      offer(1'b0, DIR_EAST);
      offer(1'b0, DIR_SOUTH);
      offer(1'b0, DIR_NORTH);
      offer(1'b0, DIR_WEST);
      wait_idle();

      // Single column maze
      set_dims(6'd1, 6'd32);
      @(posedge clock);
      offer(1'b1, DIR_WEST);
      offer(1'b0, DIR_NORTH);
      offer(1'b0, DIR_NORTH);
      offer(1'b0, DIR_SOUTH);
      wait_idle();

      // Random walks under each idling pattern
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: set_mode(0, 0);
            1: set_mode(56, 0);
            2: set_mode(0, 56);
            default: set_mode(33, 33);
         endcase
         sent = 0;
         if (mode == 0) begin
            // Hold results off while moves keep coming, so the input backs up
            set_dims(6'd32, 6'd32);
            @(posedge clock);
            offer(1'b1, DIR_WEST);
            wait_idle();
            @(posedge clock);
            hold_gen++;
            for (int i = 0; i < 60; i++) offer(1'b0, DIR_W'($urandom_range(3)));
            wait_idle();
            sent += 61;
         end
         while (sent < MODE_ITEMS) begin
            set_dims(pick_dim(), pick_dim());
            n = $urandom_range(60, 10);
            @(posedge clock);
            if ($urandom_range(99) < 85) begin
               offer(1'b1, DIR_W'($urandom_range(3)));
               sent++;
            end
            for (int i = 0; i < n; i++) begin
               offer($urandom_range(99) < 2, DIR_W'($urandom_range(3)));
            end
            wait_idle();
            sent += n;
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
